### src/tsm_pkg.sv
// tsm_pkg: shared types, operation codes, cell kinds and error codes
// for the two-stack machine core; no dependencies
package tsm_pkg;

	localparam int FUNC_W  = 5;
	localparam int KIND_W  = 2;
	localparam int VALUE_W = 63;
	localparam int ERR_W   = 3;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_NOP   = 5'd0;
	localparam logic [FUNC_W-1:0] FN_NIL   = 5'd1;
	localparam logic [FUNC_W-1:0] FN_CONST = 5'd2;
	localparam logic [FUNC_W-1:0] FN_DROP  = 5'd3;
	localparam logic [FUNC_W-1:0] FN_DUP   = 5'd4;
	localparam logic [FUNC_W-1:0] FN_SWAP  = 5'd5;
	localparam logic [FUNC_W-1:0] FN_NIP   = 5'd6;
	localparam logic [FUNC_W-1:0] FN_OVER  = 5'd7;
	localparam logic [FUNC_W-1:0] FN_BURY  = 5'd8;
	localparam logic [FUNC_W-1:0] FN_DIG   = 5'd9;
	localparam logic [FUNC_W-1:0] FN_TO_R  = 5'd10;
	localparam logic [FUNC_W-1:0] FN_FROM_R = 5'd11;
	localparam logic [FUNC_W-1:0] FN_CHOOSE = 5'd12;
	localparam logic [FUNC_W-1:0] FN_ADD   = 5'd13;
	localparam logic [FUNC_W-1:0] FN_SUB   = 5'd14;
	localparam logic [FUNC_W-1:0] FN_MUL   = 5'd15;
	localparam logic [FUNC_W-1:0] FN_DIV   = 5'd16;
	localparam logic [FUNC_W-1:0] FN_MOD   = 5'd17;
	localparam logic [FUNC_W-1:0] FN_AND_B = 5'd18;
	localparam logic [FUNC_W-1:0] FN_OR_B  = 5'd19;
	localparam logic [FUNC_W-1:0] FN_XOR_B = 5'd20;
	localparam logic [FUNC_W-1:0] FN_NOT_B = 5'd21;
	localparam logic [FUNC_W-1:0] FN_EQ    = 5'd22;
	localparam logic [FUNC_W-1:0] FN_NEQ   = 5'd23;
	localparam logic [FUNC_W-1:0] FN_LT    = 5'd24;
	localparam logic [FUNC_W-1:0] FN_GT    = 5'd25;
	localparam logic [FUNC_W-1:0] FN_LTE   = 5'd26;
	localparam logic [FUNC_W-1:0] FN_GTE   = 5'd27;
	localparam logic [FUNC_W-1:0] FN_AND_L = 5'd28;
	localparam logic [FUNC_W-1:0] FN_OR_L  = 5'd29;

	// cell kinds
	localparam logic [KIND_W-1:0] KIND_NIL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NUM = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OBJ = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
	localparam logic [ERR_W-1:0] ERR_OVER  = 3'd1;
	localparam logic [ERR_W-1:0] ERR_UNDER = 3'd2;
	localparam logic [ERR_W-1:0] ERR_TYPE  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_UNK   = 3'd4;
	localparam logic [ERR_W-1:0] ERR_DIV0  = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
	} cell_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic decode;
		logic rd_issue;
		logic rd_cap;
		logic exec;
		logic md_start;
		logic md_cap;
		logic wr;
		logic top_issue;
		logic top_cap;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_more;
		logic wr_more;
		logic md_go;
		logic md_done;
	} stat_t;

	// number of data cells an operation consumes
	function automatic logic [1:0] pops(input logic [FUNC_W-1:0] f);
		logic [1:0] n;
		case (f)
			FN_DROP, FN_DUP, FN_TO_R, FN_NOT_B: n = 2'd1;
			FN_SWAP, FN_NIP, FN_OVER: n = 2'd2;
			FN_BURY, FN_DIG, FN_CHOOSE: n = 2'd3;
			FN_NOP, FN_NIL, FN_CONST, FN_FROM_R: n = 2'd0;
			default: n = (f >= FN_ADD && f <= FN_OR_L) ? 2'd2 : 2'd0;
		endcase
		return n;
	endfunction

endpackage

### src/tsm_muldiv.sv
// tsm_muldiv: shared iterative unit for 63-bit wrapping multiply and
// truncating signed divide / modulo; depends on tsm_pkg
module tsm_muldiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          op_div,
	input  logic                          op_mod,
	input  logic [tsm_pkg::VALUE_W-1:0]   a,
	input  logic [tsm_pkg::VALUE_W-1:0]   b,
	output logic                          done,
	output logic [tsm_pkg::VALUE_W-1:0]   result
);
	import tsm_pkg::*;

	logic                busy_q, fin_q, div_q, mod_q, negq_q, negr_q;
	logic [5:0]          cnt_q;
	logic [31:0]         ma_q, mb_q, al_q, ah_q, bl_q, bh_q;
	logic [63:0]         prod_q;
	logic [VALUE_W-1:0]  acc_q, rem_q, quo_q, ub_q;
	logic [VALUE_W:0]    trial;
	logic                ge;
	logic [VALUE_W-1:0]  sub_res, abs_a, abs_b;

	// one restoring step: shift in next dividend bit, compare, subtract
	assign trial   = {rem_q, quo_q[VALUE_W-1]};
	assign ge      = trial >= {1'b0, ub_q};
	assign sub_res = ge ? VALUE_W'(trial - {1'b0, ub_q}) : trial[VALUE_W-1:0];
	assign abs_a   = a[VALUE_W-1] ? VALUE_W'(-a) : a;
	assign abs_b   = b[VALUE_W-1] ? VALUE_W'(-b) : b;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if ((div_q && cnt_q == 6'(VALUE_W - 1)) || (!div_q && cnt_q == 6'd3)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// shared 32x32 multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= ma_q * mb_q;
	end

	// operand sequencing, accumulation and divide steps
	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= op_div | op_mod;
			mod_q  <= op_mod;
			al_q   <= a[31:0];
			ah_q   <= {1'b0, a[VALUE_W-1:32]};
			bl_q   <= b[31:0];
			bh_q   <= {1'b0, b[VALUE_W-1:32]};
			ma_q   <= a[31:0];
			mb_q   <= b[31:0];
			rem_q  <= '0;
			quo_q  <= abs_a;
			ub_q   <= abs_b;
			negq_q <= a[VALUE_W-1] ^ b[VALUE_W-1];
			negr_q <= a[VALUE_W-1];
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= sub_res;
				quo_q <= {quo_q[VALUE_W-2:0], ge};
			end else begin
				case (cnt_q)
					6'd0: begin
						ma_q <= ah_q;
						mb_q <= bl_q;
					end
					6'd1: begin
						acc_q <= prod_q[VALUE_W-1:0];
						ma_q  <= al_q;
						mb_q  <= bh_q;
					end
					6'd2: acc_q <= acc_q + {prod_q[30:0], 32'd0};
					6'd3: acc_q <= acc_q + {prod_q[30:0], 32'd0};
					default: acc_q <= acc_q;
				endcase
			end
		end
	end

	// result select: product, or sign fix-up of quotient or remainder
	always_comb begin
		if (!div_q) begin
			result = acc_q;
		end else if (mod_q) begin
			result = negr_q ? VALUE_W'(-rem_q) : rem_q;
		end else begin
			result = negq_q ? VALUE_W'(-quo_q) : quo_q;
		end
	end

	assign done = fin_q;

endmodule

### src/tsm_datapath.sv
// tsm_datapath: data and retain stack memories, pointers, operand and
// result registers, alu; depends on tsm_pkg and tsm_muldiv
module tsm_datapath #(
	parameter int STACK_DEPTH = 64,
	parameter int PW          = $clog2(STACK_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsm_pkg::cmd_t                 cmd,
	output tsm_pkg::stat_t                stat,
	input  logic [tsm_pkg::FUNC_W-1:0]    func,
	input  logic [tsm_pkg::KIND_W-1:0]    literal_kind,
	input  logic [tsm_pkg::VALUE_W-1:0]   literal_value,
	output logic [tsm_pkg::KIND_W-1:0]    top_kind,
	output logic [tsm_pkg::VALUE_W-1:0]   top_value,
	output logic [PW-1:0]                 data_depth,
	output logic [PW-1:0]                 retain_depth,
	output logic [tsm_pkg::ERR_W-1:0]     error_code
);
	import tsm_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [PW-1:0] DEPTH = PW'(STACK_DEPTH);

	cell_t dmem [STACK_DEPTH];
	cell_t rmem [STACK_DEPTH];
	cell_t drd_q, rrd_q;

	logic [PW-1:0]      dp_q, rp_q, ndp_q, nrp_q;
	logic [FUNC_W-1:0]  f_q;
	logic [KIND_W-1:0]  lk_q;
	logic [VALUE_W-1:0] lv_q;
	logic [ERR_W-1:0]   err_q;
	logic [1:0]         nrd_q, rcnt_q, nr_q, wcnt_q;
	cell_t              op_q [3];
	cell_t              res_q [3];
	logic [KIND_W-1:0]  tk_q;
	logic [VALUE_W-1:0] tv_q;

	logic [1:0]         np, e_nr;
	logic [ERR_W-1:0]   d_err, e_err;
	cell_t              e_res [3];
	logic [PW-1:0]      e_ndp, e_nrp;
	logic [PW:0]        grown;
	logic [PW-1:0]      base, d_addr, w_addr;
	logic               numeric2, md_op, t;
	logic signed [VALUE_W-1:0] sa, sb;
	logic [VALUE_W-1:0] md_res;
	logic               md_done;

	assign np = pops(f_q);
	assign sa = op_q[0].value;
	assign sb = op_q[1].value;
	assign md_op = (f_q == FN_MUL) || (f_q == FN_DIV) || (f_q == FN_MOD);
	assign base = dp_q - PW'(np);

	// decode time checks: unknown opcode, underflow, from-retain overflow
	always_comb begin
		d_err = ERR_OK;
		if (f_q > FN_OR_L) begin
			d_err = ERR_UNK;
		end else if (f_q == FN_FROM_R) begin
			if (rp_q == '0) d_err = ERR_UNDER;
			else if (dp_q >= DEPTH) d_err = ERR_OVER;
		end else if (dp_q < PW'(np)) begin
			d_err = ERR_UNDER;
		end
	end

	// alu: type and range checks and results on the captured operands
	always_comb begin
		numeric2 = (f_q inside {[FN_ADD:FN_GTE]}) && (f_q != FN_NOT_B);
		e_err = err_q;
		e_nr  = 2'd1;
		for (int i = 0; i < 3; i++) begin
			e_res[i] = '{kind: KIND_NUM, value: '0};
		end
		t = 1'b0;
		case (f_q)
			FN_EQ:  t = sa == sb;
			FN_NEQ: t = sa != sb;
			FN_LT:  t = sa < sb;
			FN_GT:  t = sa > sb;
			FN_LTE: t = sa <= sb;
			default: t = sa >= sb;
		endcase
		case (f_q)
			FN_NOP, FN_DROP: e_nr = 2'd0;
			FN_NIL: e_res[0] = '{kind: KIND_NIL, value: '0};
			FN_CONST: begin
				if (lk_q == KIND_NUM || lk_q == KIND_OBJ) e_res[0] = '{kind: lk_q, value: lv_q};
				else e_res[0] = '{kind: KIND_NIL, value: '0};
			end
			FN_DUP: begin
				e_nr = 2'd2;
				e_res[0] = op_q[0];
				e_res[1] = op_q[0];
			end
			FN_SWAP: begin
				e_nr = 2'd2;
				e_res[0] = op_q[1];
				e_res[1] = op_q[0];
			end
			FN_NIP: e_res[0] = op_q[1];
			FN_OVER: begin
				e_nr = 2'd3;
				e_res[0] = op_q[0];
				e_res[1] = op_q[1];
				e_res[2] = op_q[0];
			end
			FN_BURY: begin
				e_nr = 2'd3;
				e_res[0] = op_q[2];
				e_res[1] = op_q[0];
				e_res[2] = op_q[1];
			end
			FN_DIG: begin
				e_nr = 2'd3;
				e_res[0] = op_q[1];
				e_res[1] = op_q[2];
				e_res[2] = op_q[0];
			end
			FN_TO_R, FN_FROM_R: e_res[0] = op_q[0];
			FN_CHOOSE: e_res[0] = (op_q[0].kind == KIND_NIL) ? op_q[2] : op_q[1];
			FN_ADD: e_res[0].value = op_q[0].value + op_q[1].value;
			FN_SUB: e_res[0].value = op_q[0].value - op_q[1].value;
			FN_AND_B: e_res[0].value = op_q[0].value & op_q[1].value;
			FN_OR_B:  e_res[0].value = op_q[0].value | op_q[1].value;
			FN_XOR_B: e_res[0].value = op_q[0].value ^ op_q[1].value;
			FN_NOT_B: e_res[0].value = ~op_q[0].value;
			FN_AND_L: e_res[0] = (op_q[0].kind == KIND_NIL) ? '{kind: KIND_NIL, value: '0}
				: op_q[1];
			FN_OR_L: e_res[0] = (op_q[0].kind == KIND_NIL) ? op_q[1] : op_q[0];
			FN_EQ, FN_NEQ, FN_LT, FN_GT, FN_LTE, FN_GTE:
				e_res[0] = '{kind: (t ? KIND_NUM : KIND_NIL), value: VALUE_W'(t)};
			default: e_res[0] = op_q[0];
		endcase
		// error order: type, divide by zero, overflow
		if (e_err == ERR_OK) begin
			if (numeric2 && (op_q[0].kind != KIND_NUM || op_q[1].kind != KIND_NUM))
				e_err = ERR_TYPE;
			else if (f_q == FN_NOT_B && op_q[0].kind != KIND_NUM)
				e_err = ERR_TYPE;
			else if ((f_q == FN_DIV || f_q == FN_MOD) && op_q[1].value == '0)
				e_err = ERR_DIV0;
		end
		grown = {1'b0, base} + (PW + 1)'(e_nr);
		e_ndp = grown[PW-1:0];
		e_nrp = rp_q;
		if (f_q == FN_TO_R) begin
			e_ndp = dp_q - PW'(1);
			e_nrp = rp_q + PW'(1);
		end else if (f_q == FN_FROM_R) begin
			e_ndp = dp_q + PW'(1);
			e_nrp = rp_q - PW'(1);
		end
		if (e_err == ERR_OK) begin
			if (f_q == FN_TO_R) begin
				if (rp_q >= DEPTH) e_err = ERR_OVER;
			end else if (f_q != FN_FROM_R && grown > {1'b0, DEPTH}) begin
				e_err = ERR_OVER;
			end
		end
		if (e_err != ERR_OK) begin
			e_ndp = dp_q;
			e_nrp = rp_q;
		end
	end

	// status to the controller
	assign stat.rd_more = rcnt_q < nrd_q;
	assign stat.wr_more = (err_q == ERR_OK) && (wcnt_q < nr_q);
	assign stat.md_go   = md_op && (e_err == ERR_OK);
	assign stat.md_done = md_done;

	tsm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.md_start),
		.op_div (f_q == FN_DIV),
		.op_mod (f_q == FN_MOD),
		.a      (op_q[0].value),
		.b      (op_q[1].value),
		.done   (md_done),
		.result (md_res)
	);

	// data stack read address: operand fetch or new top
	assign d_addr = cmd.top_issue ? (ndp_q - PW'(1))
		: (base + PW'(rcnt_q));

	// data stack write address
	assign w_addr = base + PW'(wcnt_q);

	// stack memories, registered reads
	always_ff @(posedge clk) begin
		drd_q <= dmem[d_addr[AW-1:0]];
		rrd_q <= rmem[rp_q[AW-1:0] - AW'(1)];
		if (cmd.wr) begin
			if (f_q == FN_TO_R) rmem[rp_q[AW-1:0]] <= res_q[wcnt_q];
			else dmem[w_addr[AW-1:0]] <= res_q[wcnt_q];
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q <= '0;
			rp_q <= '0;
		end else if (cmd.top_issue) begin
			dp_q <= ndp_q;
			rp_q <= nrp_q;
		end
	end

	// item, operand and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f_q  <= func;
			lk_q <= literal_kind;
			lv_q <= literal_value;
		end
		if (cmd.decode) begin
			err_q  <= d_err;
			rcnt_q <= '0;
			nrd_q  <= (d_err != ERR_OK) ? 2'd0 : ((f_q == FN_FROM_R) ? 2'd1 : np);
		end
		if (cmd.rd_cap) begin
			op_q[rcnt_q] <= (f_q == FN_FROM_R) ? rrd_q : drd_q;
			rcnt_q <= rcnt_q + 2'd1;
		end
		if (cmd.exec) begin
			err_q  <= e_err;
			nr_q   <= e_nr;
			wcnt_q <= '0;
			ndp_q  <= e_ndp;
			nrp_q  <= e_nrp;
			for (int i = 0; i < 3; i++) begin
				res_q[i] <= e_res[i];
			end
		end
		if (cmd.md_cap) res_q[0].value <= md_res;
		if (cmd.wr) wcnt_q <= wcnt_q + 2'd1;
		if (cmd.top_cap) begin
			tk_q <= (dp_q == '0) ? KIND_NIL : drd_q.kind;
			tv_q <= (dp_q == '0) ? '0 : drd_q.value;
		end
	end

	assign top_kind     = tk_q;
	assign top_value    = tv_q;
	assign data_depth   = dp_q;
	assign retain_depth = rp_q;
	assign error_code   = err_q;

endmodule

### src/tsm_ctrl.sv
// tsm_ctrl: one-hot sequencer that steps one instruction through decode,
// operand fetch, execute, mul/div wait, write-back and top fetch; depends on tsm_pkg
module tsm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output tsm_pkg::cmd_t   cmd,
	input  tsm_pkg::stat_t  stat
);
	import tsm_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_DECODE    = 9'b000000010,
		S_RD_ISSUE  = 9'b000000100,
		S_RD_CAP    = 9'b000001000,
		S_EXEC      = 9'b000010000,
		S_MD_WAIT   = 9'b000100000,
		S_WRITE     = 9'b001000000,
		S_TOP_ISSUE = 9'b010000000,
		S_TOP_CAP   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = S_RD_ISSUE;
			end
			S_RD_ISSUE: begin
				cmd.rd_issue = stat.rd_more;
				state_d      = stat.rd_more ? S_RD_CAP : S_EXEC;
			end
			S_RD_CAP: begin
				cmd.rd_cap = 1'b1;
				state_d    = S_RD_ISSUE;
			end
			S_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.md_start = stat.md_go;
				state_d      = stat.md_go ? S_MD_WAIT : S_WRITE;
			end
			S_MD_WAIT: begin
				if (stat.md_done) begin
					cmd.md_cap = 1'b1;
					state_d    = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.wr  = stat.wr_more;
				state_d = stat.wr_more ? S_WRITE : S_TOP_ISSUE;
			end
			S_TOP_ISSUE: begin
				cmd.top_issue = 1'b1;
				state_d       = S_TOP_CAP;
			end
			S_TOP_CAP: begin
				cmd.top_cap = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.top_cap;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

### src/two_stack_machine_core.sv
// two_stack_machine_core: top level of the two-stack machine
// depends on tsm_pkg, tsm_ctrl, tsm_datapath (with tsm_muldiv)
//
// usage:
//  - command channel: an instruction beat (func, literal_kind, literal_value)
//    is taken at a rising edge with start high and busy low
//  - result channel: done is high for exactly one cycle; top_kind,
//    top_value, data_depth, retain_depth and error_code form the result beat
//  - one instruction at a time; busy drops in the cycle done is shown, so
//    the next start can be taken while the result is on the ports
//  - latency from accept to done is set by the stack memories, with a
//    single read port each (every operand read is issued, then captured)
//    and one cell written per cycle; mul adds a pass through the shared
//    32x32 multiplier, div and mod a run of the one-bit-per-cycle divider
//  - on an error both stacks and depths are left as they were
//  - reset clears both depths and the sequencer; stack cells are not
//    cleared and no cell above the depth is ever used
//  - the receiver cannot stall: each result beat is taken in its cycle
module two_stack_machine_core #(
	parameter int STACK_DEPTH = 64,
	localparam int PW         = $clog2(STACK_DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [tsm_pkg::FUNC_W-1:0]           func,
	input  logic [tsm_pkg::KIND_W-1:0]           literal_kind,
	input  logic signed [tsm_pkg::VALUE_W-1:0]   literal_value,
	output logic                                 done,
	output logic [tsm_pkg::KIND_W-1:0]           top_kind,
	output logic signed [tsm_pkg::VALUE_W-1:0]   top_value,
	output logic [PW-1:0]                        data_depth,
	output logic [PW-1:0]                        retain_depth,
	output logic [tsm_pkg::ERR_W-1:0]            error_code
);
	import tsm_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic [VALUE_W-1:0] tv;

	// sequencer
	tsm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// stacks and alu
	tsm_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.PW          (PW)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.literal_kind  (literal_kind),
		.literal_value (literal_value),
		.top_kind      (top_kind),
		.top_value     (tv),
		.data_depth    (data_depth),
		.retain_depth  (retain_depth),
		.error_code    (error_code)
	);

	assign top_value = tv;

endmodule
